// ----- hdl/symmetric_complex_fir_filter_macros.svh -----
// Assertion macros shared by the filter RTL.
`ifndef SYMMETRIC_COMPLEX_FIR_FILTER_MACROS_SVH
`define SYMMETRIC_COMPLEX_FIR_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");
`else
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- hdl/scfir_pkg.sv -----
// Shared constants for the symmetric complex FIR filter.
`default_nettype none

package scfir_pkg;

  localparam int NUM_TAPS_DEF = 65;
  localparam int SAMPLE_W     = 16;
  localparam int TAP_W        = 18;
  localparam int TIDX_W       = 6;
  localparam int SHIFT_W      = 5;
  localparam int PRE_W        = SAMPLE_W + 1;
  localparam int PROD_W       = PRE_W + TAP_W;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(16);

  localparam logic CMD_TAP_WRITE = 1'b0;
  localparam logic CMD_FILTER    = 1'b1;

endpackage

`default_nettype wire

// ----- hdl/symmetric_complex_fir_filter.sv -----
// Symmetric complex FIR filter top level: control, pre-add MAC and output scaling.
//
// Input channel (in_valid / in_stall): command selects a tap write or a sample.
//   A tap write stores tap_value at tap_index (ignored when tap_index >= HALF_TAPS);
//   it gives no output beat.
//   A sample beat goes into the delay line and starts one filter pass. The pass
//   walks the HALF_TAPS tap steps through a shared pre-add multiplier for each of
//   I and Q, one step per cycle, reading both delay-line ends from two RAM copies.
// Output channel (out_valid / out_stall): one beat of out_i, out_q, clipped per
//   sample, after the pass has run through ST_RUN, ST_DRAIN, ST_ROUND, ST_SHIFT
//   and ST_SAT; in_stall is high for the whole pass.
// The result sits in an output register, so the next beat is accepted while it
//   waits. If the receiver stalls past the end of the next pass, that pass
//   holds its result until the register frees up.
// Config channel (cfg_valid / cfg_ready): cfg_data sets the output shift; write
//   it only while idle.
// Reset (rst, synchronous) clears the delay line and taps through per-entry
//   valid bits, sets the shift to 16 and drops out_valid; no clearing pass.
`default_nettype none

`include "symmetric_complex_fir_filter_macros.svh"

module symmetric_complex_fir_filter #(
  parameter int NUM_TAPS = scfir_pkg::NUM_TAPS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  command,
  input  wire logic [scfir_pkg::TIDX_W-1:0]          tap_index,
  input  wire logic signed [scfir_pkg::TAP_W-1:0]    tap_value,
  input  wire logic signed [scfir_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic signed [scfir_pkg::SAMPLE_W-1:0] sample_q,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [scfir_pkg::SAMPLE_W-1:0]      out_i,
  output logic signed [scfir_pkg::SAMPLE_W-1:0]      out_q,
  output logic                                       clipped,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [scfir_pkg::SHIFT_W-1:0]         cfg_data
);

  localparam int HALF_TAPS = (NUM_TAPS + 1) / 2;
  localparam int PW        = $clog2(NUM_TAPS);
  localparam int TW        = $clog2(HALF_TAPS);
  localparam int SW        = scfir_pkg::SAMPLE_W;
  localparam int ACC_W     = scfir_pkg::PROD_W + $clog2(HALF_TAPS + 1);
  localparam int RW        = ACC_W + 1;
  localparam logic signed [RW-1:0] SAT_HI = RW'(2 ** (SW - 1) - 1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_SHIFT,
    ST_SAT
  } state_t;

  state_t state;

  logic [PW-1:0] wr_pos;
  logic [PW-1:0] a_ptr;
  logic [PW-1:0] b_ptr;
  logic [TW-1:0] step;
  logic          is_center;

  logic [NUM_TAPS-1:0]  line_vld;
  logic [HALF_TAPS-1:0] tap_vld;
  logic [scfir_pkg::SHIFT_W-1:0] out_shift;

  logic s1, s2, s3;
  logic va, vb, vt;

  logic [2*SW-1:0]                     line_a_rd;
  logic [2*SW-1:0]                     line_b_rd;
  logic [scfir_pkg::TAP_W-1:0]         tap_rd;
  logic signed [scfir_pkg::PRE_W-1:0]  pre_i, pre_q;
  logic signed [scfir_pkg::TAP_W-1:0]  tap_r;
  logic signed [scfir_pkg::PROD_W-1:0] prod_i, prod_q;
  logic signed [ACC_W-1:0]             acc_i, acc_q;
  logic signed [RW-1:0]                rnd_i, rnd_q;
  logic signed [RW-1:0]                shf_i, shf_q;
  logic [RW-1:0]                       rnd_const;

  logic             accept;
  logic             line_we;
  logic             tap_we;
  logic [TW+5:0]    tidx_ext;
  logic [TW-1:0]    tap_waddr;
  logic [PW-1:0]    wr_pos_next;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign line_we   = accept && (command == scfir_pkg::CMD_FILTER);
  assign tidx_ext  = (TW + 6)'(tap_index);
  assign tap_waddr = tidx_ext[TW-1:0];
  assign tap_we    = accept && (command == scfir_pkg::CMD_TAP_WRITE)
                     && (32'(tap_index) < HALF_TAPS);
  assign wr_pos_next = (wr_pos == PW'(NUM_TAPS - 1)) ? '0 : wr_pos + PW'(1);
  assign is_center   = (step == TW'(HALF_TAPS - 1));
  assign rnd_const   = ({{(RW-1){1'b0}}, 1'b1} << out_shift) >> 1;

  scfir_ram #(.WIDTH(2 * SW), .DEPTH(NUM_TAPS)) u_line_a (
    .clk   (clk),
    .we    (line_we),
    .waddr (wr_pos),
    .wdata ({sample_q, sample_i}),
    .raddr (a_ptr),
    .rdata (line_a_rd)
  );

  scfir_ram #(.WIDTH(2 * SW), .DEPTH(NUM_TAPS)) u_line_b (
    .clk   (clk),
    .we    (line_we),
    .waddr (wr_pos),
    .wdata ({sample_q, sample_i}),
    .raddr (b_ptr),
    .rdata (line_b_rd)
  );

  scfir_ram #(.WIDTH(scfir_pkg::TAP_W), .DEPTH(HALF_TAPS)) u_taps (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_value),
    .raddr (step),
    .rdata (tap_rd)
  );

  function automatic logic [SW:0] saturate(input logic signed [RW-1:0] v);
    logic [SW:0] r;
    if (v > SAT_HI) begin
      r = {1'b1, SAT_HI[SW-1:0]};
    end else if (v < SAT_LO) begin
      r = {1'b1, SAT_LO[SW-1:0]};
    end else begin
      r = {1'b0, v[SW-1:0]};
    end
    return r;
  endfunction

  logic [SW:0] sat_i, sat_q;
  assign sat_i = saturate(shf_i);
  assign sat_q = saturate(shf_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_pos    <= '0;
      line_vld  <= '0;
      tap_vld   <= '0;
      out_shift <= scfir_pkg::SHIFT_RESET;
      out_valid <= 1'b0;
      s1        <= 1'b0;
      s2        <= 1'b0;
      s3        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        out_shift <= cfg_data;
      end
      if (state == ST_SAT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (tap_we) begin
        tap_vld[tap_waddr] <= 1'b1;
      end

      // pre-add stage
      s2 <= s1;
      pre_i <= (va ? {line_a_rd[SW-1], line_a_rd[SW-1:0]} : '0)
             + (vb ? {line_b_rd[SW-1], line_b_rd[SW-1:0]} : '0);
      pre_q <= (va ? {line_a_rd[2*SW-1], line_a_rd[2*SW-1:SW]} : '0)
             + (vb ? {line_b_rd[2*SW-1], line_b_rd[2*SW-1:SW]} : '0);
      tap_r <= vt ? tap_rd : '0;

      // multiply stage
      s3 <= s2;
      prod_i <= pre_i * tap_r;
      prod_q <= pre_q * tap_r;

      // accumulate stage
      if (line_we) begin
        acc_i <= '0;
        acc_q <= '0;
      end else if (s3) begin
        acc_i <= acc_i + ACC_W'(prod_i);
        acc_q <= acc_q + ACC_W'(prod_q);
      end

      s1 <= (state == ST_RUN);
      case (state)
        ST_IDLE: begin
          if (line_we) begin
            line_vld[wr_pos] <= 1'b1;
            a_ptr  <= wr_pos;
            b_ptr  <= wr_pos_next;
            wr_pos <= wr_pos_next;
            step   <= '0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          va    <= line_vld[a_ptr];
          vb    <= line_vld[b_ptr] && !is_center;
          vt    <= tap_vld[step];
          a_ptr <= (a_ptr == '0) ? PW'(NUM_TAPS - 1) : a_ptr - PW'(1);
          b_ptr <= (b_ptr == PW'(NUM_TAPS - 1)) ? '0 : b_ptr + PW'(1);
          step  <= step + TW'(1);
          if (is_center) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1 && !s2 && !s3) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd_i <= RW'(acc_i) + rnd_const;
          rnd_q <= RW'(acc_q) + rnd_const;
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          shf_i <= rnd_i >>> out_shift;
          shf_q <= rnd_q >>> out_shift;
          state <= ST_SAT;
        end
        ST_SAT: begin
          if (!out_valid || !out_stall) begin
            out_i     <= sat_i[SW-1:0];
            out_q     <= sat_q[SW-1:0];
            clipped   <= sat_i[SW] | sat_q[SW];
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_pass_holds_input, line_we, in_stall)
  `ASSERT_SAME(a_idle_pipe_empty, state == ST_IDLE, !s1 && !s2 && !s3)
  `ASSERT_SAME(a_wr_pos_range, 1'b1, wr_pos <= PW'(NUM_TAPS - 1))
  `ASSERT_SAME(a_result_from_sat, $rose(out_valid), $past(state == ST_SAT))

endmodule

`default_nettype wire

// ----- hdl/scfir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scfir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
